// ----- rtl/psst_pkg.sv -----
// Package for the packet source statistics block.
// Holds payload structs, command and state types and shared constants.
// No dependencies.
package psst_pkg;

  localparam int TABLE_DEPTH_DEF  = 256;
  localparam int REPORT_LIMIT_DEF = 16;

  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;
  localparam logic [7:0]  PROTO_ICMP = 8'd1;

  localparam logic [4:0] HOSTS_TO_REPORT_RST = 5'd5;

  localparam logic ACT_ACCOUNT = 1'b0;
  localparam logic ACT_REPORT  = 1'b1;
  localparam logic KIND_SUMMARY = 1'b0;
  localparam logic KIND_HOST    = 1'b1;

  typedef struct packed {
    logic        action;
    logic [15:0] ether_type;
    logic [7:0]  ip_protocol;
    logic [31:0] source_address;
    logic [16:0] frame_length;
  } in_data_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] packets_total;
    logic [47:0] bytes_total;
    logic [31:0] tcp_total;
    logic [31:0] udp_total;
    logic [31:0] icmp_total;
    logic [31:0] other_total;
    logic [8:0]  hosts_seen;
    logic [3:0]  rank;
    logic [31:0] host_address;
    logic [31:0] host_packets;
    logic        last;
  } out_data_t;

  typedef enum logic [1:0] {
    CLS_TCP,
    CLS_UDP,
    CLS_ICMP,
    CLS_OTHER
  } proto_cls_t;

  typedef struct packed {
    logic        is_report;
    logic        is_ipv4;
    proto_cls_t  cls;
    logic [31:0] src;
    logic [16:0] flen;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC_RD,
    ST_ACC_CMP,
    ST_ACC_INS,
    ST_SORT_LDI,
    ST_SORT_LDW,
    ST_SORT_RD,
    ST_SORT_CMP,
    ST_SORT_WR,
    ST_SUM,
    ST_HOST_RD,
    ST_HOST_EMIT
  } back_state_t;

endpackage

// ----- rtl/psst_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module psst_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/psst_fifo.sv -----
// Two-entry queue with push/full and pop/empty sides.
// No dependencies.
module psst_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] slot_r [2];
  logic             wp_r, rp_r;
  logic [1:0]       cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= wdata;
    end
  end

endmodule

// ----- rtl/psst_front.sv -----
// Front end: accepts input beats, classifies them and queues commands.
// Depends on psst_pkg and psst_fifo.
module psst_front
  import psst_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  in_data_t in_data,
  output logic     full,
  input  logic     cmd_pop,
  output cmd_t     cmd,
  output logic     cmd_empty
);

  cmd_t cmd_in;

  always_comb begin
    cmd_in.is_report = (in_data.action == ACT_REPORT);
    cmd_in.is_ipv4   = (in_data.ether_type == ETYPE_IPV4);
    cmd_in.src       = in_data.source_address;
    cmd_in.flen      = in_data.frame_length;
    if (!cmd_in.is_ipv4) begin
      cmd_in.cls = CLS_OTHER;
    end else if (in_data.ip_protocol == PROTO_TCP) begin
      cmd_in.cls = CLS_TCP;
    end else if (in_data.ip_protocol == PROTO_UDP) begin
      cmd_in.cls = CLS_UDP;
    end else if (in_data.ip_protocol == PROTO_ICMP) begin
      cmd_in.cls = CLS_ICMP;
    end else begin
      cmd_in.cls = CLS_OTHER;
    end
  end

  psst_fifo #(.WIDTH($bits(cmd_t))) u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (cmd_in),
    .full  (full),
    .pop   (cmd_pop),
    .rdata (cmd),
    .empty (cmd_empty)
  );

endmodule

// ----- rtl/psst_back.sv -----
// Back end: counters, host table search and insert, exchange sort, report.
// Depends on psst_pkg and psst_ram.
module psst_back
  import psst_pkg::*;
#(
  parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF,
  parameter int REPORT_LIMIT = REPORT_LIMIT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic [4:0] hosts_to_report,
  input  cmd_t      cmd,
  input  logic      cmd_empty,
  output logic      cmd_pop,
  output logic      res_push,
  output out_data_t res,
  input  logic      res_full
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int KW = $clog2(REPORT_LIMIT + 1);

  back_state_t state_r, state_nxt;

  logic [31:0] pkt_r, tcp_r, udp_r, icmp_r, oth_r;
  logic [47:0] byt_r;
  logic [CW-1:0] used_r;
  logic [IW-1:0] i_r, j_r;
  logic [KW-1:0] count_r;
  logic [31:0]   src_r;
  logic [31:0]   cur_addr_r, cur_hits_r;

  logic          we;
  logic [IW-1:0] waddr, raddr;
  logic [63:0]   wdata, rdata;
  logic [31:0]   rd_addr, rd_hits;

  logic        hit, j_last, i_last, k_last, swap, room;
  logic [15:0] lim16, cnt16;

  assign rd_addr = rdata[63:32];
  assign rd_hits = rdata[31:0];
  assign hit     = (rd_addr == src_r);
  assign j_last  = (16'(j_r) + 16'd1 == 16'(used_r));
  assign i_last  = (16'(i_r) + 16'd2 == 16'(used_r));
  assign k_last  = (16'(j_r) + 16'd1 == 16'(count_r));
  assign swap    = (cur_hits_r < rd_hits);
  assign room    = (16'(used_r) < 16'(TABLE_DEPTH));

  always_comb begin
    lim16 = (16'(hosts_to_report) > 16'(REPORT_LIMIT)) ? 16'(REPORT_LIMIT)
                                                        : 16'(hosts_to_report);
    cnt16 = (lim16 > 16'(used_r)) ? 16'(used_r) : lim16;
  end

  psst_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!cmd_empty) begin
          if (cmd.is_report) begin
            state_nxt = (16'(used_r) < 16'd2) ? ST_SUM : ST_SORT_LDI;
          end else if (cmd.is_ipv4) begin
            state_nxt = (used_r == '0) ? ST_ACC_INS : ST_ACC_RD;
          end
        end
      end
      ST_ACC_RD:  state_nxt = ST_ACC_CMP;
      ST_ACC_CMP: begin
        priority if (hit)  state_nxt = ST_IDLE;
        else if (j_last)   state_nxt = ST_ACC_INS;
        else               state_nxt = ST_ACC_RD;
      end
      ST_ACC_INS:  state_nxt = ST_IDLE;
      ST_SORT_LDI: state_nxt = ST_SORT_LDW;
      ST_SORT_LDW: state_nxt = ST_SORT_RD;
      ST_SORT_RD:  state_nxt = ST_SORT_CMP;
      ST_SORT_CMP: state_nxt = j_last ? ST_SORT_WR : ST_SORT_RD;
      ST_SORT_WR:  state_nxt = i_last ? ST_SUM : ST_SORT_LDI;
      ST_SUM: begin
        if (!res_full) state_nxt = (count_r == '0) ? ST_IDLE : ST_HOST_RD;
      end
      ST_HOST_RD: state_nxt = ST_HOST_EMIT;
      ST_HOST_EMIT: begin
        if (!res_full) state_nxt = k_last ? ST_IDLE : ST_HOST_RD;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop  = (state_r == ST_IDLE) && !cmd_empty;
    res_push = ((state_r == ST_SUM) || (state_r == ST_HOST_EMIT)) && !res_full;
    raddr    = (state_r == ST_SORT_LDI) ? i_r : j_r;
    we       = 1'b0;
    waddr    = j_r;
    wdata    = {cur_addr_r, cur_hits_r};
    unique case (state_r)
      ST_ACC_CMP: begin
        we    = hit;
        wdata = {rd_addr, rd_hits + 32'd1};
      end
      ST_ACC_INS: begin
        we    = room;
        waddr = IW'(used_r);
        wdata = {src_r, 32'd1};
      end
      ST_SORT_CMP: begin
        we = swap;
      end
      ST_SORT_WR: begin
        we    = 1'b1;
        waddr = i_r;
      end
      default: ;
    endcase
    res = '0;
    if (state_r == ST_SUM) begin
      res.kind          = KIND_SUMMARY;
      res.packets_total = pkt_r;
      res.bytes_total   = byt_r;
      res.tcp_total     = tcp_r;
      res.udp_total     = udp_r;
      res.icmp_total    = icmp_r;
      res.other_total   = oth_r;
      res.hosts_seen    = 9'(used_r);
      res.last          = (count_r == '0);
    end else begin
      res.kind         = KIND_HOST;
      res.rank         = 4'(j_r);
      res.host_address = rd_addr;
      res.host_packets = rd_hits;
      res.last         = k_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pkt_r   <= '0;
      byt_r   <= '0;
      tcp_r   <= '0;
      udp_r   <= '0;
      icmp_r  <= '0;
      oth_r   <= '0;
      used_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (cmd_pop && !cmd.is_report) begin
        pkt_r <= pkt_r + 32'd1;
        byt_r <= byt_r + 48'(cmd.flen);
        unique case (cmd.cls)
          CLS_TCP:  tcp_r  <= tcp_r + 32'd1;
          CLS_UDP:  udp_r  <= udp_r + 32'd1;
          CLS_ICMP: icmp_r <= icmp_r + 32'd1;
          default:  oth_r  <= oth_r + 32'd1;
        endcase
      end
      if (state_r == ST_ACC_INS && room) begin
        used_r <= used_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        src_r   <= cmd.src;
        j_r     <= '0;
        i_r     <= '0;
        count_r <= KW'(cnt16);
      end
      ST_ACC_CMP: begin
        j_r <= j_r + IW'(1);
      end
      ST_SORT_LDW: begin
        cur_addr_r <= rd_addr;
        cur_hits_r <= rd_hits;
        j_r        <= i_r + IW'(1);
      end
      ST_SORT_CMP: begin
        if (swap) begin
          cur_addr_r <= rd_addr;
          cur_hits_r <= rd_hits;
        end
        j_r <= j_r + IW'(1);
      end
      ST_SORT_WR: begin
        i_r <= i_r + IW'(1);
      end
      ST_SUM: begin
        j_r <= '0;
      end
      ST_HOST_EMIT: begin
        if (!res_full) j_r <= j_r + IW'(1);
      end
      default: ;
    endcase
  end

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    16'(used_r) <= 16'(TABLE_DEPTH))
    else $error("table occupancy beyond depth");

  a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(used_r)) |->
      (used_r == $past(used_r) + CW'(1) && $past(state_r) == ST_ACC_INS))
    else $error("table occupancy moved outside insert");

  a_host_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HOST_EMIT) |-> (16'(j_r) < 16'(count_r)))
    else $error("host rank past report length");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_pop && cmd.is_report) |=> (state_r == ST_SUM || state_r == ST_SORT_LDI))
    else $error("report did not start sort or summary");

endmodule

// ----- rtl/packet_source_statistics_top.sv -----
// Top level of the packet source statistics block.
// Depends on psst_pkg, psst_front, psst_back, psst_fifo.
//
// Accepts account and report beats on a push/full queue port and returns
// results on an empty/pop queue port. An account beat for a non-IPv4 frame
// only updates the counters. An IPv4 account beat also searches the occupied
// host entries in turn, reading and then comparing one table RAM entry per
// step, and inserts the source if it is not found. A report beat runs an
// in-place exchange sort over the table, then emits one summary and up to
// hosts_to_report host results, capped at REPORT_LIMIT. Two-entry queues on both
// sides let input be taken while results wait. No clearing pass is needed.
module packet_source_statistics_top
  import psst_pkg::*;
#(
  parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF,
  parameter int REPORT_LIMIT = REPORT_LIMIT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  in_data_t  in_data,
  output logic      full,
  input  logic      pop,
  output out_data_t out_data,
  output logic      empty,
  input  logic      cfg_we,
  input  logic [4:0] cfg_data
);

  logic [4:0] hosts_to_report_r;
  cmd_t       cmd;
  logic       cmd_empty, cmd_pop;
  logic       res_push, res_full;
  out_data_t  res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hosts_to_report_r <= HOSTS_TO_REPORT_RST;
    end else if (cfg_we) begin
      hosts_to_report_r <= cfg_data;
    end
  end

  psst_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .in_data   (in_data),
    .full      (full),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .cmd_empty (cmd_empty)
  );

  psst_back #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .REPORT_LIMIT (REPORT_LIMIT)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .hosts_to_report (hosts_to_report_r),
    .cmd             (cmd),
    .cmd_empty       (cmd_empty),
    .cmd_pop         (cmd_pop),
    .res_push        (res_push),
    .res             (res),
    .res_full        (res_full)
  );

  psst_fifo #(.WIDTH($bits(out_data_t))) u_resq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .rdata (out_data),
    .empty (empty)
  );

endmodule
